>>> hdl/assert_macros.svh
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked on every clock edge outside reset
`define PSU_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked on every clock edge, reset included
`define PSU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> hdl/psu_pkg.sv
// shared types, constants and helpers for the particle swarm update block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package psu_pkg;
   localparam int SwarmSize = 64;
   localparam int SlotWidth = $clog2(SwarmSize);
   localparam logic [31:0] MaxPos = 32'h7FFF_FFFF;
   localparam logic [31:0] MinNeg = 32'h8000_0000;

   // actions
   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_UPDATE = 2'd1;
   localparam logic [1:0] ACT_GEN    = 2'd2;

   // register indexes
   localparam logic [2:0] REG_INERTIA = 3'd0;
   localparam logic [2:0] REG_COG     = 3'd1;
   localparam logic [2:0] REG_SOC     = 3'd2;
   localparam logic [2:0] REG_XLO     = 3'd3;
   localparam logic [2:0] REG_XHI     = 3'd4;
   localparam logic [2:0] REG_YLO     = 3'd5;
   localparam logic [2:0] REG_YHI     = 3'd6;

   // operand selection for the shared multiplier
   typedef struct packed {
      logic        go;
      logic [33:0] a;
      logic [33:0] b;
   } mul_req_type;

   // saturate a wide signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [67:0] hi;
      logic signed [67:0] lo;
      hi = 68'sh7FFF_FFFF;
      lo = -68'sh8000_0000;
      if (v > hi) return MaxPos;
      if (v < lo) return MinNeg;
      return v[31:0];
   endfunction
endpackage
`default_nettype wire

>>> hdl/psu_ram.sv
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module psu_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

>>> hdl/psu_mul.sv
// shared signed 34x34 multiplier, result registered
// depends on psu_pkg
`timescale 1ns / 1ps
`default_nettype none
module psu_mul (
   input  wire logic                 clock,
   input  wire psu_pkg::mul_req_type req,
   output logic signed [67:0]        prod_ff
);
   import psu_pkg::*;
   logic signed [67:0] prod_in;

   // one product per cycle
   always_comb begin
      prod_in = $signed(req.a) * $signed(req.b);
   end

   always_ff @(posedge clock) begin
      if (req.go) prod_ff <= prod_in;
   end
endmodule
`default_nettype wire

>>> hdl/particle_swarm_update.sv
// Particle swarm update engine, two-dimensional global best, Q16.16.
// Input channel req_*: one action per transfer (load, update, start generation).
// Result channel rsp_*: one result per accepted action, held until taken.
// Config channel csr_*: index and data, written when csr_valid and csr_ready.
// Throughput: one item at a time; req_stall is high while an item is in work.
// Every product (four coefficients, six velocity terms, one fitness product)
// is performed in sequence by the shared multiplier. Load works only the
// fitness product; update also works coefficients, velocity and position;
// start generation and unused actions go straight to the result. req_stall
// falls in the same cycle as rsp_valid rises.
// Particle table in seven 64-entry rams with registered read.
// Reset clears the sequencer, the running best (largest positive value), the
// guide and the configuration registers to their defaults; the particle table
// is undefined until loaded.
// When the receiver stalls, the result stays on rsp_*; one more item may enter
// and is worked, then waits until the held result is taken.
// Configuration may be written only when the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module particle_swarm_update (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [5:0]  req_slot,
   input  wire logic [31:0] req_load_x,
   input  wire logic [31:0] req_load_y,
   input  wire logic [31:0] req_load_vx,
   input  wire logic [31:0] req_load_vy,
   input  wire logic [15:0] req_rand_cog_x,
   input  wire logic [15:0] req_rand_soc_x,
   input  wire logic [15:0] req_rand_cog_y,
   input  wire logic [15:0] req_rand_soc_y,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_new_x,
   output logic [31:0]      rsp_new_y,
   output logic [31:0]      rsp_fitness,
   output logic             rsp_personal_improved,
   output logic [31:0]      rsp_best_value,
   output logic [31:0]      rsp_best_x,
   output logic [31:0]      rsp_best_y,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   import psu_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_RD    = 5'd1;
   localparam logic [4:0] S_KCX   = 5'd2;
   localparam logic [4:0] S_KSX   = 5'd3;
   localparam logic [4:0] S_KCY   = 5'd4;
   localparam logic [4:0] S_KSY   = 5'd5;
   localparam logic [4:0] S_WVX   = 5'd6;
   localparam logic [4:0] S_CX    = 5'd7;
   localparam logic [4:0] S_SX    = 5'd8;
   localparam logic [4:0] S_WVY   = 5'd9;
   localparam logic [4:0] S_CY    = 5'd10;
   localparam logic [4:0] S_SY    = 5'd11;
   localparam logic [4:0] S_POS   = 5'd12;
   localparam logic [4:0] S_CLAMP = 5'd13;
   localparam logic [4:0] S_FIT   = 5'd14;
   localparam logic [4:0] S_FWAIT = 5'd15;
   localparam logic [4:0] S_DONE  = 5'd16;
   localparam logic [4:0] S_OUT   = 5'd17;
   localparam logic [4:0] S_KWAIT = 5'd18;

   logic [4:0] state_ff, state_in;

   // configuration registers
   logic [15:0] w_ff, c1_ff, c2_ff;
   logic [31:0] xlo_ff, xhi_ff, ylo_ff, yhi_ff;

   // running best and guide
   logic [31:0] rv_ff, rv_in, rx_ff, rx_in, ry_ff, ry_in, gx_ff, gx_in, gy_ff, gy_in;

   // captured item
   logic [1:0]  act_ff, act_in;
   logic [5:0]  slot_ff, slot_in;
   logic [31:0] lx_ff, lx_in, ly_ff, ly_in, lvx_ff, lvx_in, lvy_ff, lvy_in;
   logic [15:0] r_ff [4];
   logic [15:0] r_in [4];

   // work registers
   logic [15:0] k_ff [4];
   logic [15:0] k_in [4];
   logic signed [67:0] acc_ff, acc_in;
   logic [31:0] vx_ff, vx_in, vy_ff, vy_in, nx_ff, nx_in, ny_ff, ny_in;
   logic [31:0] fit_ff, fit_in;
   logic        imp_ff, imp_in;

   // output register
   logic        ov_ff, ov_in;
   logic [31:0] onx_ff, onx_in, ony_ff, ony_in, ofit_ff, ofit_in;
   logic        oimp_ff, oimp_in;
   logic [31:0] obv_ff, obv_in, obx_ff, obx_in, oby_ff, oby_in;

   // rams
   logic        we;
   logic        wep;
   logic [31:0] px_q, py_q, vxq, vyq, bx_q, by_q, bv_q;
   logic [31:0] wpx, wpy, wvx, wvy;

   mul_req_type        mreq;
   logic signed [67:0] prod;

   psu_ram #(.Width(32), .Depth(SwarmSize)) u_px (.clock, .wr_en(we), .addr(slot_ff),
      .wr_data(wpx), .rd_data(px_q));
   psu_ram #(.Width(32), .Depth(SwarmSize)) u_py (.clock, .wr_en(we), .addr(slot_ff),
      .wr_data(wpy), .rd_data(py_q));
   psu_ram #(.Width(32), .Depth(SwarmSize)) u_vx (.clock, .wr_en(we), .addr(slot_ff),
      .wr_data(wvx), .rd_data(vxq));
   psu_ram #(.Width(32), .Depth(SwarmSize)) u_vy (.clock, .wr_en(we), .addr(slot_ff),
      .wr_data(wvy), .rd_data(vyq));
   psu_ram #(.Width(32), .Depth(SwarmSize)) u_bx (.clock, .wr_en(wep), .addr(slot_ff),
      .wr_data(nx_ff), .rd_data(bx_q));
   psu_ram #(.Width(32), .Depth(SwarmSize)) u_by (.clock, .wr_en(wep), .addr(slot_ff),
      .wr_data(ny_ff), .rd_data(by_q));
   psu_ram #(.Width(32), .Depth(SwarmSize)) u_bv (.clock, .wr_en(wep), .addr(slot_ff),
      .wr_data(fit_ff), .rd_data(bv_q));

   psu_mul u_mul (.clock, .req(mreq), .prod_ff(prod));

   logic signed [67:0] shp12;
   logic signed [31:0] pxc, pyc;
   logic signed [67:0] psum;
   logic signed [31:0] ptmp;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !ov_ff;
   assign rsp_valid = ov_ff;
   assign rsp_new_x = onx_ff;
   assign rsp_new_y = ony_ff;
   assign rsp_fitness = ofit_ff;
   assign rsp_personal_improved = oimp_ff;
   assign rsp_best_value = obv_ff;
   assign rsp_best_x = obx_ff;
   assign rsp_best_y = oby_ff;

   assign shp12 = prod >>> 12;
   assign wpx = (act_ff == ACT_LOAD) ? lx_ff : nx_ff;
   assign wpy = (act_ff == ACT_LOAD) ? ly_ff : ny_ff;
   assign wvx = (act_ff == ACT_LOAD) ? lvx_ff : vx_ff;
   assign wvy = (act_ff == ACT_LOAD) ? lvy_ff : vy_ff;

   // sequencer and datapath
   always_comb begin
      state_in = state_ff;
      rv_in = rv_ff; rx_in = rx_ff; ry_in = ry_ff; gx_in = gx_ff; gy_in = gy_ff;
      act_in = act_ff; slot_in = slot_ff;
      lx_in = lx_ff; ly_in = ly_ff; lvx_in = lvx_ff; lvy_in = lvy_ff;
      r_in = r_ff; k_in = k_ff;
      acc_in = acc_ff; vx_in = vx_ff; vy_in = vy_ff; nx_in = nx_ff; ny_in = ny_ff;
      fit_in = fit_ff; imp_in = imp_ff;
      ov_in = ov_ff; onx_in = onx_ff; ony_in = ony_ff; ofit_in = ofit_ff; oimp_in = oimp_ff;
      obv_in = obv_ff; obx_in = obx_ff; oby_in = oby_ff;
      we = 1'b0; wep = 1'b0;
      mreq = '0;
      pxc = '0; pyc = '0; psum = '0; ptmp = '0;
      if (ov_ff && !rsp_stall) ov_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in = req_action; slot_in = req_slot[SlotWidth-1:0];
               lx_in = req_load_x; ly_in = req_load_y;
               lvx_in = req_load_vx; lvy_in = req_load_vy;
               r_in[0] = req_rand_cog_x; r_in[1] = req_rand_soc_x;
               r_in[2] = req_rand_cog_y; r_in[3] = req_rand_soc_y;
               nx_in = '0; ny_in = '0; fit_in = '0; imp_in = 1'b0;
               case (req_action)
                  ACT_LOAD: begin
                     nx_in = req_load_x; ny_in = req_load_y;
                     state_in = S_FIT;
                  end
                  ACT_UPDATE: state_in = S_KCX;
                  ACT_GEN: begin
                     gx_in = rx_ff; gy_in = ry_ff;
                     state_in = S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         // coefficients: k = gain * rand >> 16
         S_KCX: begin
            mreq = '{go: 1'b1, a: {18'd0, c1_ff}, b: {18'd0, r_ff[0]}};
            state_in = S_KSX;
         end
         S_KSX: begin
            k_in[0] = prod[31:16];
            mreq = '{go: 1'b1, a: {18'd0, c2_ff}, b: {18'd0, r_ff[1]}};
            state_in = S_KCY;
         end
         S_KCY: begin
            k_in[1] = prod[31:16];
            mreq = '{go: 1'b1, a: {18'd0, c1_ff}, b: {18'd0, r_ff[2]}};
            state_in = S_KSY;
         end
         S_KSY: begin
            k_in[2] = prod[31:16];
            mreq = '{go: 1'b1, a: {18'd0, c2_ff}, b: {18'd0, r_ff[3]}};
            state_in = S_KWAIT;
         end
         S_KWAIT: begin
            k_in[3] = prod[31:16];
            state_in = S_RD;
         end
         // ram data valid here; inertia x
         S_RD: begin
            mreq = '{go: 1'b1, a: {18'd0, w_ff}, b: {{2{vxq[31]}}, vxq}};
            state_in = S_WVX;
         end
         S_WVX: begin
            acc_in = shp12;
            mreq = '{go: 1'b1, a: {18'd0, k_ff[0]},
                     b: {{2{bx_q[31]}}, bx_q} - {{2{px_q[31]}}, px_q}};
            state_in = S_CX;
         end
         S_CX: begin
            acc_in = acc_ff + shp12;
            mreq = '{go: 1'b1, a: {18'd0, k_ff[1]},
                     b: {{2{gx_ff[31]}}, gx_ff} - {{2{px_q[31]}}, px_q}};
            state_in = S_SX;
         end
         S_SX: begin
            vx_in = sat32(acc_ff + shp12);
            mreq = '{go: 1'b1, a: {18'd0, w_ff}, b: {{2{vyq[31]}}, vyq}};
            state_in = S_WVY;
         end
         S_WVY: begin
            acc_in = shp12;
            mreq = '{go: 1'b1, a: {18'd0, k_ff[2]},
                     b: {{2{by_q[31]}}, by_q} - {{2{py_q[31]}}, py_q}};
            state_in = S_CY;
         end
         S_CY: begin
            acc_in = acc_ff + shp12;
            mreq = '{go: 1'b1, a: {18'd0, k_ff[3]},
                     b: {{2{gy_ff[31]}}, gy_ff} - {{2{py_q[31]}}, py_q}};
            state_in = S_SY;
         end
         S_SY: begin
            vy_in = sat32(acc_ff + shp12);
            state_in = S_POS;
         end
         // position with saturation
         S_POS: begin
            psum = 68'($signed(px_q)) + 68'($signed(vx_ff));
            nx_in = sat32(psum);
            psum = 68'($signed(py_q)) + 68'($signed(vy_ff));
            ny_in = sat32(psum);
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            pxc = nx_ff;
            if ($signed(pxc) < $signed(xlo_ff)) pxc = xlo_ff;
            if ($signed(pxc) > $signed(xhi_ff)) pxc = xhi_ff;
            pyc = ny_ff;
            if ($signed(pyc) < $signed(ylo_ff)) pyc = ylo_ff;
            if ($signed(pyc) > $signed(yhi_ff)) pyc = yhi_ff;
            nx_in = pxc; ny_in = pyc;
            state_in = S_FIT;
         end
         // fitness product
         S_FIT: begin
            mreq = '{go: 1'b1, a: {{2{nx_ff[31]}}, nx_ff}, b: {{2{ny_ff[31]}}, ny_ff}};
            state_in = S_FWAIT;
         end
         S_FWAIT: begin
            fit_in = sat32(prod >>> 16);
            state_in = S_OUT;
         end
         // write back and best tracking
         S_OUT: begin
            we = 1'b1;
            ptmp = fit_ff;
            if (act_ff == ACT_LOAD || $signed(ptmp) < $signed(bv_q)) begin
               wep = 1'b1;
               imp_in = 1'b1;
            end
            if ($signed(ptmp) < $signed(rv_ff)) begin
               rv_in = fit_ff; rx_in = nx_ff; ry_in = ny_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!ov_ff) begin
               ov_in = 1'b1;
               onx_in = nx_ff; ony_in = ny_ff; ofit_in = fit_ff; oimp_in = imp_ff;
               obv_in = rv_ff; obx_in = rx_ff; oby_in = ry_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff <= 1'b0;
         obv_ff <= MaxPos; obx_ff <= '0; oby_ff <= '0;
         rv_ff <= MaxPos; rx_ff <= '0; ry_ff <= '0; gx_ff <= '0; gy_ff <= '0;
         w_ff <= 16'd3686; c1_ff <= 16'd6144; c2_ff <= 16'd6144;
         xlo_ff <= 32'hFFFB_0000; xhi_ff <= 32'd327680;
         ylo_ff <= 32'hFFFB_0000; yhi_ff <= 32'd327680;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
         obv_ff <= obv_in; obx_ff <= obx_in; oby_ff <= oby_in;
         rv_ff <= rv_in; rx_ff <= rx_in; ry_ff <= ry_in; gx_ff <= gx_in; gy_ff <= gy_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_INERTIA: w_ff <= csr_data[15:0];
               REG_COG: c1_ff <= csr_data[15:0];
               REG_SOC: c2_ff <= csr_data[15:0];
               REG_XLO: xlo_ff <= csr_data;
               REG_XHI: xhi_ff <= csr_data;
               REG_YLO: ylo_ff <= csr_data;
               REG_YHI: yhi_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff <= act_in; slot_ff <= slot_in;
      lx_ff <= lx_in; ly_ff <= ly_in; lvx_ff <= lvx_in; lvy_ff <= lvy_in;
      r_ff <= r_in; k_ff <= k_in;
      acc_ff <= acc_in; vx_ff <= vx_in; vy_ff <= vy_in; nx_ff <= nx_in; ny_ff <= ny_in;
      fit_ff <= fit_in; imp_ff <= imp_in;
      onx_ff <= onx_in; ony_ff <= ony_in; ofit_ff <= ofit_in; oimp_ff <= oimp_in;
   end
endmodule
`default_nettype wire

>>> hdl/psu_checker.sv
// port-level checks for the particle swarm update block, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module psu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_best_value,
   input wire logic        csr_ready
);
   // a result is held while stalled
   `PSU_ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp dropped")
   // an accepted item stalls the input next cycle
   `PSU_ASSERT_CLK(a_busy, clock, reset, req_valid && !req_stall |=> req_stall, "not busy")
   // config is closed while a result waits
   `PSU_ASSERT_CLK(a_csr, clock, reset, rsp_valid |-> !csr_ready, "csr open")
   // the running best never grows
   `PSU_ASSERT_CLK(a_best, clock, reset,
      !$past(reset) |-> $signed(rsp_best_value) <= $signed($past(rsp_best_value)), "best grew")
endmodule
bind particle_swarm_update psu_checker u_psu_checker (.*);
`default_nettype wire

>>> tb/sv/tb_particle_swarm_update.sv
// testbench for the particle swarm update block: directed table, then random actions
// depends on psu_pkg and particle_swarm_update; a local predictor checks every result
`timescale 1ns / 1ps
`default_nettype none
module tb_particle_swarm_update;
   import psu_pkg::*;

   localparam int CycleLimit = 2000000;
   localparam logic [1:0] ACT_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [5:0]  slot;
      logic [31:0] lx, ly, lvx, lvy;
      logic [15:0] rcx, rsx, rcy, rsy;
   } action_type;

   typedef struct packed {
      logic [31:0] nx, ny, fit;
      logic        improved;
      logic [31:0] bval, bx, by;
   } outcome_type;

   // directed row: stimulus plus optional typed-in expectation
   typedef struct packed {
      action_type  act;
      logic        typed;
      outcome_type want;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_action = '0;
   logic [5:0] req_slot = '0;
   logic [31:0] req_load_x = '0, req_load_y = '0, req_load_vx = '0, req_load_vy = '0;
   logic [15:0] req_rand_cog_x = '0, req_rand_soc_x = '0;
   logic [15:0] req_rand_cog_y = '0, req_rand_soc_y = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [31:0] rsp_new_x, rsp_new_y, rsp_fitness, rsp_best_value, rsp_best_x, rsp_best_y;
   logic rsp_personal_improved;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   particle_swarm_update dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // swarm state mirror
   logic [15:0] inertia, cog_gain, soc_gain;
   logic signed [31:0] xlo, xhi, ylo, yhi;
   logic signed [31:0] pos_x [64], pos_y [64], vel_x [64], vel_y [64];
   logic signed [31:0] pb_x [64], pb_y [64], pb_val [64];
   bit loaded [64];
   logic signed [31:0] run_val, run_x, run_y, gd_x, gd_y;

   outcome_type pending_results [$];
   int errors = 0;
   int cycles = 0;
   int hold_off = 0;
   bit drain = 0;

   function automatic logic signed [63:0] floor_sh(logic signed [63:0] v, int s);
      return v >>> s;
   endfunction

   function automatic logic signed [31:0] sat(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [63:0] pull_term(logic [15:0] gain, logic [15:0] r,
                                                    logic signed [31:0] tgt,
                                                    logic signed [31:0] p);
      logic signed [63:0] k, d;
      k = (64'(gain) * 64'(r)) >> 16;
      d = 64'(tgt) - 64'(p);
      return floor_sh(k * d, 12);
   endfunction

   function automatic logic signed [31:0] product_fit(logic signed [31:0] x,
                                                      logic signed [31:0] y);
      return sat(floor_sh(64'(x) * 64'(y), 16));
   endfunction

   function automatic void predictor_reset();
      inertia = 3686; cog_gain = 6144; soc_gain = 6144;
      xlo = -327680; xhi = 327680; ylo = -327680; yhi = 327680;
      run_val = 32'sh7FFFFFFF; run_x = 0; run_y = 0; gd_x = 0; gd_y = 0;
      foreach (loaded[i]) loaded[i] = 0;
   endfunction

   function automatic void note_best(logic signed [31:0] f, x, y);
      if (f < run_val) begin
         run_val = f; run_x = x; run_y = y;
      end
   endfunction

   function automatic outcome_type predict_swarm(action_type a);
      outcome_type o;
      logic signed [63:0] vx, vy;
      logic signed [31:0] svx, svy, nx, ny, f;
      int s;
      s = a.slot;
      nx = 0; ny = 0; f = 0;
      o.improved = 0;
      if (a.action == ACT_GEN) begin
         gd_x = run_x; gd_y = run_y;
      end else if (a.action == ACT_LOAD) begin
         nx = a.lx; ny = a.ly;
         pos_x[s] = nx; pos_y[s] = ny; vel_x[s] = a.lvx; vel_y[s] = a.lvy;
         f = product_fit(nx, ny);
         pb_x[s] = nx; pb_y[s] = ny; pb_val[s] = f;
         loaded[s] = 1;
         o.improved = 1;
         note_best(f, nx, ny);
      end else if (a.action == ACT_UPDATE) begin
         vx = floor_sh(64'($signed({1'b0, inertia})) * 64'(vel_x[s]), 12)
            + pull_term(cog_gain, a.rcx, pb_x[s], pos_x[s])
            + pull_term(soc_gain, a.rsx, gd_x, pos_x[s]);
         vy = floor_sh(64'($signed({1'b0, inertia})) * 64'(vel_y[s]), 12)
            + pull_term(cog_gain, a.rcy, pb_y[s], pos_y[s])
            + pull_term(soc_gain, a.rsy, gd_y, pos_y[s]);
         svx = sat(vx); svy = sat(vy);
         nx = sat(64'(pos_x[s]) + 64'(svx));
         if (nx < xlo) nx = xlo;
         if (nx > xhi) nx = xhi;
         ny = sat(64'(pos_y[s]) + 64'(svy));
         if (ny < ylo) ny = ylo;
         if (ny > yhi) ny = yhi;
         vel_x[s] = svx; vel_y[s] = svy; pos_x[s] = nx; pos_y[s] = ny;
         f = product_fit(nx, ny);
         note_best(f, nx, ny);
         if (f < pb_val[s]) begin
            pb_val[s] = f; pb_x[s] = nx; pb_y[s] = ny;
            o.improved = 1;
         end
      end
      o.nx = nx; o.ny = ny; o.fit = f;
      o.bval = run_val; o.bx = run_x; o.by = run_y;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // sampled at the edge, compared against the oldest expectation
   always @(posedge clock) begin
      outcome_type w;
      cycles++;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("unexpected result transfer at %0t", $realtime);
            errors++;
         end else begin
            w = pending_results.pop_front();
            if (rsp_new_x !== w.nx) report_mismatch("new_x", rsp_new_x, w.nx);
            if (rsp_new_y !== w.ny) report_mismatch("new_y", rsp_new_y, w.ny);
            if (rsp_fitness !== w.fit) report_mismatch("fitness", rsp_fitness, w.fit);
            if (rsp_personal_improved !== w.improved)
               report_mismatch("improved", rsp_personal_improved, w.improved);
            if (rsp_best_value !== w.bval) report_mismatch("best_value", rsp_best_value, w.bval);
            if (rsp_best_x !== w.bx) report_mismatch("best_x", rsp_best_x, w.bx);
            if (rsp_best_y !== w.by) report_mismatch("best_y", rsp_best_y, w.by);
         end
      end
      if (cycles > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver stall: random gaps, one long hold-off on request
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1;
      end else if (drain) begin
         rsp_stall <= 0;
      end else if ($urandom_range(99) < 25) begin
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   function automatic logic [15:0] rand_frac();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(9))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom;
         default: return 32'($signed($urandom_range(1310720)) - 655360);
      endcase
   endfunction

   // valid stays high between back-to-back transfers
   task automatic send_action(action_type a);
      int gap;
      gap = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(2);
      if ($urandom_range(3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      {req_action, req_slot, req_load_x, req_load_y, req_load_vx, req_load_vy,
       req_rand_cog_x, req_rand_soc_x, req_rand_cog_y, req_rand_soc_y} <= a;
      do @(posedge clock); while (req_stall);
      pending_results = {pending_results, predict_swarm(a)};
   endtask

   task automatic write_register(logic [2:0] idx, logic [31:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         REG_INERTIA: inertia = data[15:0];
         REG_COG:     cog_gain = data[15:0];
         REG_SOC:     soc_gain = data[15:0];
         REG_XLO:     xlo = data;
         REG_XHI:     xhi = data;
         REG_YLO:     ylo = data;
         default:     yhi = data;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      drain = 1;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      drain = 0;
   endtask

   function automatic action_type make_action(logic [1:0] op, logic [5:0] s);
      action_type a;
      a.action = op; a.slot = s;
      a.lx = rand_coord(); a.ly = rand_coord();
      a.lvx = rand_coord(); a.lvy = rand_coord();
      a.rcx = rand_frac(); a.rsx = rand_frac(); a.rcy = rand_frac(); a.rsy = rand_frac();
      return a;
   endfunction

   row_type directed [$];

   task automatic build_directed();
      row_type r;
      r = '0;
      // start generation straight after reset: zero position, default best
      r.act.action = ACT_GEN; r.typed = 1;
      r.want = '{0, 0, 0, 0, 32'h7FFFFFFF, 0, 0};
      directed = {directed, r};
      // unused action code
      r.act.action = ACT_NONE; r.act.slot = 6'd63;
      directed = {directed, r};
      // load at origin: fitness zero becomes best
      r = '0; r.act.action = ACT_LOAD; r.typed = 1;
      r.want = '{0, 0, 0, 1, 0, 0, 0};
      directed = {directed, r};
      // load at extreme corners, saturated fitness
      r = '0; r.act.action = ACT_LOAD; r.act.slot = 6'd63;
      r.act.lx = 32'h7FFFFFFF; r.act.ly = 32'h80000000;
      r.act.lvx = 32'h80000000; r.act.lvy = 32'h7FFFFFFF; r.typed = 1;
      r.want = '{32'h7FFFFFFF, 32'h80000000, 32'h80000000, 1, 32'h80000000,
                 32'h7FFFFFFF, 32'h80000000};
      directed = {directed, r};
      r = '0; r.act.action = ACT_LOAD; r.act.slot = 6'd1;
      r.act.lx = 32'h80000000; r.act.ly = 32'h80000000;
      r.act.lvx = 32'h7FFFFFFF; r.act.lvy = 32'h80000000;
      directed = {directed, r};
      r = '0; r.act.action = ACT_GEN;
      directed = {directed, r};
      // updates with extreme fractions, clamped positions
      r = '0; r.act.action = ACT_UPDATE; r.act.slot = 6'd63;
      r.act.rcx = 16'hFFFF; r.act.rsx = 16'hFFFF; r.act.rcy = 16'hFFFF; r.act.rsy = 16'hFFFF;
      directed = {directed, r};
      r.act.slot = 6'd1;
      directed = {directed, r};
      r.act.slot = 6'd0;
      r.act.rcx = 0; r.act.rsx = 0; r.act.rcy = 0; r.act.rsy = 0;
      directed = {directed, r};
      r.act.slot = 6'd63;
      directed = {directed, r};
      // same point twice: equal fitness is not an improvement
      r = '0; r.act.action = ACT_LOAD; r.act.slot = 6'd2;
      r.act.lx = 32'h00010000; r.act.ly = 32'hFFFF0000;
      directed = {directed, r};
      r.act.slot = 6'd3;
      directed = {directed, r};
      r = '0; r.act.action = ACT_UPDATE; r.act.slot = 6'd2;
      directed = {directed, r};
      r = '0; r.act.action = ACT_GEN;
      directed = {directed, r};
   endtask

   initial begin
      action_type a;
      int slot;
      int n_loaded;
      predictor_reset();
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      build_directed();
      foreach (directed[i]) begin
         send_action(directed[i].act);
         if (directed[i].typed && pending_results[$] !== directed[i].want) begin
            $display("directed row %0d disagrees with predictor", i);
            errors++;
         end
      end
      wait_idle();

      // random phases under several register settings
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1: begin
               write_register(REG_INERTIA, 32'hFFFF);
               write_register(REG_COG, 32'hFFFF);
               write_register(REG_SOC, 32'hFFFF);
               write_register(REG_XLO, 32'h80000000);
               write_register(REG_XHI, 32'h7FFFFFFF);
               write_register(REG_YLO, 32'h80000000);
               write_register(REG_YHI, 32'h7FFFFFFF);
            end
            2: begin
               write_register(REG_INERTIA, 0);
               write_register(REG_COG, 0);
               write_register(REG_SOC, 0);
               // crossed bounds: upper wins
               write_register(REG_XLO, 32'h00050000);
               write_register(REG_XHI, 32'hFFFB0000);
               write_register(REG_YLO, 32'h7FFFFFFF);
               write_register(REG_YHI, 32'h80000000);
            end
            3, 4: begin
               write_register(REG_INERTIA, $urandom_range(65535));
               write_register(REG_COG, $urandom_range(65535));
               write_register(REG_SOC, $urandom_range(65535));
               write_register(REG_XLO, -$urandom_range(1 << 22));
               write_register(REG_XHI, $urandom_range(1 << 22));
               write_register(REG_YLO, -$urandom_range(1 << 22));
               write_register(REG_YHI, $urandom_range(1 << 22));
            end
            default: ;
         endcase
         if (phase == 2) hold_off = 400;
         n_loaded = 0;
         foreach (loaded[i]) if (loaded[i]) n_loaded++;
         for (int k = 0; k < 400; k++) begin
            slot = $urandom_range(63);
            case ($urandom_range(19))
               0, 1: a = make_action(ACT_LOAD, slot);
               2: a = make_action(ACT_GEN, slot);
               3: a = make_action(ACT_NONE, slot);
               default: begin
                  if (!loaded[slot]) a = make_action(ACT_LOAD, slot);
                  else a = make_action(ACT_UPDATE, slot);
               end
            endcase
            send_action(a);
         end
         wait_idle();
      end

      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
`default_nettype wire
